// ===== rtl/core/actb_pkg.sv =====
// shared codes, widths and reset values for the action cost token bucket
`default_nettype none

package actb_pkg;

  // field widths
  localparam int unsigned OpW       = 2;
  localparam int unsigned ActionW   = 5;
  localparam int unsigned CostW     = 8;
  localparam int unsigned BalanceW  = 20;
  localparam int unsigned RegenW    = 16;
  localparam int unsigned RateW     = 18;
  localparam int unsigned AuthW     = 2;
  localparam int unsigned TotalW    = 32;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 64;

  // operation codes
  localparam logic [OpW-1:0] OP_CHECK = 2'd0;
  localparam logic [OpW-1:0] OP_BURN  = 2'd1;
  localparam logic [OpW-1:0] OP_TICK  = 2'd2;
  localparam logic [OpW-1:0] OP_INIT  = 2'd3;

  // authority levels
  localparam logic [AuthW-1:0] AUTH_KERNEL  = 2'd0;
  localparam logic [AuthW-1:0] AUTH_ADMIN   = 2'd1;
  localparam logic [AuthW-1:0] AUTH_SERVICE = 2'd2;
  localparam logic [AuthW-1:0] AUTH_USER    = 2'd3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_MAX_BASE   = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_REGEN_BASE = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_AUTHORITY  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_COST_LOW   = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_COST_MID   = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_COST_HIGH  = 3'd5;

  // register reset values
  localparam logic [BalanceW-1:0] MAX_BASE_RESET   = 20'd1000;
  localparam logic [RegenW-1:0]   REGEN_BASE_RESET = 16'd10;
  localparam logic [AuthW-1:0]    AUTHORITY_RESET  = AUTH_USER;

  // cost table word: eight byte-wide costs
  typedef logic [7:0][CostW-1:0] cost_word_t;

  // cost charged for a zero table entry or an unlisted action
  localparam logic [CostW-1:0] COST_DEFAULT = 8'd1;

endpackage

`default_nettype wire

// ===== rtl/core/actb_ifs.sv =====
// item channels of the action cost token bucket: request, result, configuration
`default_nettype none

interface actb_req_if;
  logic                             valid;
  logic                             ready;
  logic [actb_pkg::OpW-1:0]         op;
  logic [actb_pkg::ActionW-1:0]     action;
  modport source (output valid, op, action, input ready);
  modport sink   (input valid, op, action, output ready);
endinterface

interface actb_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [actb_pkg::CostW-1:0]       applied_cost;
  logic [actb_pkg::BalanceW-1:0]    balance_now;
  logic                             starved_now;
  logic [actb_pkg::TotalW-1:0]      burned_total;
  logic [actb_pkg::TotalW-1:0]      regen_total;
  modport source (output valid, ok, applied_cost, balance_now, starved_now,
                  burned_total, regen_total, input ready);
  modport sink   (input valid, ok, applied_cost, balance_now, starved_now,
                  burned_total, regen_total, output ready);
endinterface

interface actb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [actb_pkg::CfgIndexW-1:0]   index;
  logic [actb_pkg::CfgDataW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/action_cost_token_bucket_unit.sv =====
// top level of the action cost token bucket: per-action cost, check, burn, refill and init
//
//  channel  role   payload
//  req      sink   op, action
//  rsp      source ok, applied_cost, balance_now, starved_now, burned_total, regen_total
//  cfg      sink   index, data (always ready)
//
//  one item per cycle sustained while results are taken; each accepted item passes
//  through the input register, then the result register, updating the bucket state at that edge
//  the single add/subtract-and-clamp on the balance sets the critical path
//  a stalled result holds the input register, which still takes an item when empty
//  synchronous reset: balance, latched capacity and rate, flag and totals go to zero
`default_nettype none

module action_cost_token_bucket_unit #(
  parameter int unsigned NUM_ACTIONS = 18
) (
  input  wire logic clk,
  input  wire logic rst,
  actb_req_if.sink   req,
  actb_rsp_if.source rsp,
  actb_cfg_if.sink   cfg
);

  localparam int unsigned BW = actb_pkg::BalanceW;
  localparam int unsigned TW = actb_pkg::TotalW;
  localparam logic [5:0]  NumActs = 6'(NUM_ACTIONS);

  // configuration registers
  logic [BW-1:0]                      max_base;
  logic [actb_pkg::RegenW-1:0]        regen_base;
  logic [actb_pkg::AuthW-1:0]         auth_level;
  actb_pkg::cost_word_t               cost_low;
  actb_pkg::cost_word_t               cost_mid;
  actb_pkg::cost_word_t               cost_high;

  // bucket state
  logic [BW-1:0]                      balance;
  logic                               starved;
  logic [TW-1:0]                      burned_count;
  logic [TW-1:0]                      regen_count;
  logic [BW-1:0]                      cap_latched;
  logic [actb_pkg::RateW-1:0]         rate_latched;

  // input register
  logic                               s1_valid;
  logic [actb_pkg::OpW-1:0]           s1_op;
  logic [actb_pkg::ActionW-1:0]       s1_action;

  // next values
  logic [BW-1:0]                      balance_next;
  logic                               starved_next;
  logic [TW-1:0]                      burned_count_next;
  logic [TW-1:0]                      regen_count_next;
  logic [BW-1:0]                      cap_latched_next;
  logic [actb_pkg::RateW-1:0]         rate_latched_next;
  logic                               ok_next;

  logic                               s1_adv;
  actb_pkg::cost_word_t               cost_word;
  logic [actb_pkg::CostW-1:0]         cost_byte;
  logic [actb_pkg::CostW-1:0]         cost;
  logic [BW:0]                        tick_sum;
  logic [BW+1:0]                      max_x3;

  // configuration writes, always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_base        <= actb_pkg::MAX_BASE_RESET;
      regen_base      <= actb_pkg::REGEN_BASE_RESET;
      auth_level      <= actb_pkg::AUTHORITY_RESET;
      cost_low        <= '0;
      cost_mid        <= '0;
      cost_high       <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        actb_pkg::REG_MAX_BASE:   max_base        <= cfg.data[BW-1:0];
        actb_pkg::REG_REGEN_BASE: regen_base      <= cfg.data[actb_pkg::RegenW-1:0];
        actb_pkg::REG_AUTHORITY:  auth_level      <= cfg.data[actb_pkg::AuthW-1:0];
        actb_pkg::REG_COST_LOW:   cost_low        <= cfg.data;
        actb_pkg::REG_COST_MID:   cost_mid        <= cfg.data;
        actb_pkg::REG_COST_HIGH:  cost_high       <= cfg.data;
        default: ;
      endcase
    end
  end

  // handshake: input register moves on when the result register is free
  assign s1_adv    = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op     <= req.op;
      s1_action <= req.action;
    end
  end

  // cost lookup: zero entry or unlisted action costs one
  always_comb begin
    case (s1_action[4:3])
      2'd0:    cost_word = cost_low;
      2'd1:    cost_word = cost_mid;
      default: cost_word = cost_high;
    endcase
    cost_byte = cost_word[s1_action[2:0]];
    if ({1'b0, s1_action} >= NumActs || s1_action[4:3] == 2'd3 || cost_byte == '0) begin
      cost = actb_pkg::COST_DEFAULT;
    end else begin
      cost = cost_byte;
    end
  end

  // operation datapath
  always_comb begin
    balance_next      = balance;
    starved_next      = starved;
    burned_count_next = burned_count;
    regen_count_next  = regen_count;
    cap_latched_next  = cap_latched;
    rate_latched_next = rate_latched;
    ok_next           = 1'b1;
    tick_sum          = {1'b0, balance} + (BW+1)'(rate_latched);
    max_x3            = {2'b00, max_base} + {1'b0, max_base, 1'b0};
    unique case (s1_op)
      actb_pkg::OP_CHECK: begin
        ok_next = balance >= BW'(cost);
      end
      actb_pkg::OP_BURN: begin
        if (balance < BW'(cost)) begin
          starved_next = 1'b1;
          ok_next      = 1'b0;
        end else begin
          balance_next      = balance - BW'(cost);
          burned_count_next = burned_count + TW'(cost);
          starved_next      = (balance == BW'(cost));
        end
      end
      actb_pkg::OP_TICK: begin
        if (rate_latched != '0) begin
          if (balance < cap_latched) begin
            if (tick_sum > {1'b0, cap_latched}) begin
              balance_next = cap_latched;
            end else begin
              balance_next = tick_sum[BW-1:0];
            end
            regen_count_next = regen_count + TW'(balance_next - balance);
          end
          if (balance_next != '0) begin
            starved_next = 1'b0;
          end
        end
      end
      actb_pkg::OP_INIT: begin
        unique case (auth_level)
          actb_pkg::AUTH_KERNEL: begin
            cap_latched_next  = max_base;
            rate_latched_next = {regen_base, 2'b00};
          end
          actb_pkg::AUTH_ADMIN: begin
            cap_latched_next  = max_x3[BW+1:2];
            rate_latched_next = {1'b0, regen_base, 1'b0};
          end
          actb_pkg::AUTH_SERVICE: begin
            cap_latched_next  = {1'b0, max_base[BW-1:1]};
            rate_latched_next = {2'b00, regen_base};
          end
          default: begin
            cap_latched_next  = {2'b00, max_base[BW-1:2]};
            rate_latched_next = {3'b000, regen_base[actb_pkg::RegenW-1:1]};
          end
        endcase
        balance_next      = cap_latched_next;
        starved_next      = 1'b0;
        burned_count_next = '0;
        regen_count_next  = '0;
      end
      default: ;
    endcase
  end

  // bucket state update
  always_ff @(posedge clk) begin
    if (rst) begin
      balance      <= '0;
      starved      <= 1'b0;
      burned_count <= '0;
      regen_count  <= '0;
      cap_latched  <= '0;
      rate_latched <= '0;
    end else if (s1_adv) begin
      balance      <= balance_next;
      starved      <= starved_next;
      burned_count <= burned_count_next;
      regen_count  <= regen_count_next;
      cap_latched  <= cap_latched_next;
      rate_latched <= rate_latched_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (!rsp.valid || rsp.ready) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.ok           <= ok_next;
      rsp.applied_cost <= cost;
      rsp.balance_now  <= balance_next;
      rsp.starved_now  <= starved_next;
      rsp.burned_total <= burned_count_next;
      rsp.regen_total  <= regen_count_next;
    end
  end

  // checks on the bucket and the result stage
  a_balance_capped: assert property (@(posedge clk) disable iff (rst)
    balance <= cap_latched)
    else $error("balance above latched capacity");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid)
    else $error("stalled result dropped");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_op == actb_pkg::OP_INIT) |=>
      (burned_count == '0 && regen_count == '0 && balance == cap_latched && !starved))
    else $error("init did not refill and clear");

  a_zero_rate_tick: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_op == actb_pkg::OP_TICK && rate_latched == '0) |=>
      ($stable(balance) && $stable(starved) && $stable(regen_count)))
    else $error("tick with zero rate changed state");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (rsp.balance_now == balance && rsp.starved_now == starved))
    else $error("result disagrees with bucket state");

endmodule

`default_nettype wire

// ===== tb/tb_action_cost_token_bucket_unit.sv =====
// testbench for the action cost token bucket: directed, random and back-pressure traffic
`timescale 1ns / 100ps

module tb_action_cost_token_bucket_unit;
  import actb_pkg::*;

  localparam int unsigned NUM_ACT     = 18;
  localparam int unsigned TABLE_SLOTS = 24;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  // indexes that map to no register
  localparam logic [CfgIndexW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                ok;
    logic [CostW-1:0]    cost;
    logic [BalanceW-1:0] balance;
    logic                starved;
    logic [TotalW-1:0]   burned;
    logic [TotalW-1:0]   regen;
  } bucket_result_t;

  logic clk = 1'b0;
  logic rst;

  actb_req_if req_if ();
  actb_rsp_if rsp_if ();
  actb_cfg_if cfg_if ();

  action_cost_token_bucket_unit #(.NUM_ACTIONS(NUM_ACT)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  always #5 clk = ~clk;

  // register copies and bucket state of the predictor
  logic [BalanceW-1:0] reg_max_base   = MAX_BASE_RESET;
  logic [RegenW-1:0]   reg_regen_base = REGEN_BASE_RESET;
  logic [AuthW-1:0]    reg_authority  = AUTHORITY_RESET;
  cost_word_t          reg_costs [3]  = '{default: '0};
  logic [BalanceW-1:0] bucket_balance  = '0;
  logic [BalanceW-1:0] bucket_capacity = '0;
  logic [RateW-1:0]    bucket_rate     = '0;
  logic                bucket_starved  = 1'b0;
  logic [TotalW-1:0]   burned_sum      = '0;
  logic [TotalW-1:0]   regen_sum       = '0;

  bucket_result_t pending_results [$];
  int unsigned    fail_count   = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    idle_pct     = 0;
  int unsigned    stall_pct    = 0;
  int unsigned    hold_left    = 0;

  // cost of an action, with the default for unlisted or empty entries
  function automatic logic [CostW-1:0] cost_of(input logic [ActionW-1:0] action);
    logic [CostW-1:0] c;
    if (action >= NUM_ACT || action >= TABLE_SLOTS) return COST_DEFAULT;
    c = reg_costs[action[4:3]][action[2:0]];
    return (c == '0) ? COST_DEFAULT : c;
  endfunction

  task automatic apply_register(input logic [CfgIndexW-1:0] index,
                                input logic [CfgDataW-1:0] data);
    case (index)
      REG_MAX_BASE:   reg_max_base = data[BalanceW-1:0];
      REG_REGEN_BASE: reg_regen_base = data[RegenW-1:0];
      REG_AUTHORITY:  reg_authority = data[AuthW-1:0];
      REG_COST_LOW:   reg_costs[0] = data;
      REG_COST_MID:   reg_costs[1] = data;
      REG_COST_HIGH:  reg_costs[2] = data;
      default: ;
    endcase
  endtask

  // advance the bucket by one item and return the result it should give
  task automatic bucket_step(input logic [OpW-1:0] op, input logic [ActionW-1:0] action,
                             output bucket_result_t res);
    logic [CostW-1:0] cost;
    logic [31:0]      sum;
    logic [31:0]      wide_cap;
    logic             ok;
    cost = cost_of(action);
    ok = 1'b1;
    case (op)
      OP_CHECK: ok = (bucket_balance >= cost);
      OP_BURN: begin
        if (bucket_balance < cost) begin
          bucket_starved = 1'b1;
          ok = 1'b0;
        end else begin
          bucket_balance = bucket_balance - cost;
          burned_sum = burned_sum + cost;
          bucket_starved = (bucket_balance == '0);
        end
      end
      OP_TICK: begin
        if (bucket_rate != '0) begin
          if (bucket_balance < bucket_capacity) begin
            sum = 32'(bucket_balance) + 32'(bucket_rate);
            if (sum > 32'(bucket_capacity)) sum = 32'(bucket_capacity);
            regen_sum = regen_sum + (sum - 32'(bucket_balance));
            bucket_balance = sum[BalanceW-1:0];
          end
          if (bucket_balance != '0) bucket_starved = 1'b0;
        end
      end
      default: begin
        // init latches capacity and rate from the scaled base registers
        case (reg_authority)
          AUTH_KERNEL: begin
            wide_cap = 32'(reg_max_base);
            bucket_rate = {reg_regen_base, 2'b00};
          end
          AUTH_ADMIN: begin
            wide_cap = (32'(reg_max_base) * 3) / 4;
            bucket_rate = {1'b0, reg_regen_base, 1'b0};
          end
          AUTH_SERVICE: begin
            wide_cap = 32'(reg_max_base) / 2;
            bucket_rate = RateW'(reg_regen_base);
          end
          default: begin
            wide_cap = 32'(reg_max_base) / 4;
            bucket_rate = RateW'(reg_regen_base >> 1);
          end
        endcase
        bucket_capacity = wide_cap[BalanceW-1:0];
        bucket_balance = bucket_capacity;
        bucket_starved = 1'b0;
        burned_sum = '0;
        regen_sum = '0;
      end
    endcase
    res = '{ok, cost, bucket_balance, bucket_starved, burned_sum, regen_sum};
  endtask

  task automatic note_failure(input string what, input bucket_result_t want,
                              input bucket_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s at %0t: expected ok=%0d cost=%0d bal=%0d starved=%0d burned=%0d regen=%0d",
               what, $time, want.ok, want.cost, want.balance, want.starved,
               want.burned, want.regen);
      $display("  got ok=%0d cost=%0d bal=%0d starved=%0d burned=%0d regen=%0d",
               got.ok, got.cost, got.balance, got.starved, got.burned, got.regen);
    end
  endtask

  // register writes and accepted items feed the predictor
  always @(posedge clk) begin : predict_proc
    bucket_result_t res;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.index, cfg_if.data);
      if (req_if.valid && req_if.ready) begin
        bucket_step(req_if.op, req_if.action, res);
        pending_results.push_back(res);
      end
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_proc
    bucket_result_t want;
    bucket_result_t got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.ok, rsp_if.applied_cost, rsp_if.balance_now, rsp_if.starved_now,
              rsp_if.burned_total, rsp_if.regen_total};
      if (pending_results.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (want !== got) note_failure("result mismatch", want, got);
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(input logic [OpW-1:0] op, input logic [ActionW-1:0] action);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.op <= op;
    req_if.action <= action;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // stop offering items and let every expected result drain out
  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  function automatic cost_word_t rand_cost_word();
    cost_word_t w;
    for (int b = 0; b < 8; b++) begin
      case ($urandom_range(9))
        0, 1:    w[b] = '0;
        2:       w[b] = '1;
        default: w[b] = CostW'($urandom);
      endcase
    end
    return w;
  endfunction

  // random register settings, biased towards small buckets that run dry
  task automatic randomise_settings();
    logic [BalanceW-1:0] max_base;
    logic [RegenW-1:0]   regen_base;
    case ($urandom_range(9))
      0:       max_base = '0;
      1:       max_base = '1;
      2, 3:    max_base = BalanceW'($urandom);
      default: max_base = BalanceW'($urandom_range(1, 2000));
    endcase
    case ($urandom_range(9))
      0:       regen_base = '0;
      1:       regen_base = '1;
      2:       regen_base = RegenW'($urandom);
      default: regen_base = RegenW'($urandom_range(1, 64));
    endcase
    write_reg(REG_MAX_BASE, {$urandom, $urandom} & ~64'(BalanceW'('1)) | 64'(max_base));
    write_reg(REG_REGEN_BASE, 64'(regen_base));
    write_reg(REG_AUTHORITY, 64'($urandom_range(3)));
    write_reg(REG_COST_LOW, rand_cost_word());
    write_reg(REG_COST_MID, rand_cost_word());
    write_reg(REG_COST_HIGH, rand_cost_word());
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned r;
    logic [OpW-1:0] op;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40) op = OP_BURN;
      else if (r < 68) op = OP_TICK;
      else if (r < 93) op = OP_CHECK;
      else op = OP_INIT;
      send_item(op, ActionW'($urandom_range(31)));
    end
  endtask

  // nothing latched yet: burns refused, ticks do nothing
  task automatic test_before_init();
    send_item(OP_CHECK, 5'd0);
    send_item(OP_BURN, 5'd31);
    send_item(OP_TICK, 5'd5);
    send_item(OP_CHECK, 5'd18);
  endtask

  // full-size bucket at kernel level, costs from every part of the table
  task automatic test_cost_lookup();
    wait_idle();
    write_reg(REG_MAX_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_REGEN_BASE, 64'h0000_0000_0000_FFFF);
    write_reg(REG_AUTHORITY, 64'(AUTH_KERNEL));
    write_reg(REG_COST_LOW, 64'h0100_807F_0000_02FF);
    write_reg(REG_COST_MID, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_COST_HIGH, 64'hFFFF_FFFF_FFFF_FE00);
    send_item(OP_INIT, 5'd3);
    send_item(OP_BURN, 5'd0);
    send_item(OP_BURN, 5'd1);
    send_item(OP_BURN, 5'd2);
    send_item(OP_BURN, 5'd15);
    send_item(OP_BURN, 5'd16);
    send_item(OP_BURN, 5'd17);
    send_item(OP_BURN, 5'd23);
    send_item(OP_BURN, 5'd31);
    // refill overshoots and clamps at capacity
    send_item(OP_TICK, 5'd9);
    send_item(OP_CHECK, 5'd0);
  endtask

  // register changes after init leave capacity and rate alone
  task automatic test_latched_limits();
    wait_idle();
    write_reg(REG_AUTHORITY, 64'(AUTH_USER));
    write_reg(REG_MAX_BASE, 64'h0);
    write_reg(REG_REGEN_BASE, 64'h0);
    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    send_item(OP_BURN, 5'd8);
    send_item(OP_TICK, 5'd8);
    send_item(OP_CHECK, 5'd31);
  endtask

  // empty bucket with zero rate, then a tiny bucket drained and refilled
  task automatic test_zero_rate_and_drain();
    send_item(OP_INIT, 5'd0);
    send_item(OP_BURN, 5'd5);
    send_item(OP_TICK, 5'd5);
    wait_idle();
    write_reg(REG_MAX_BASE, 64'd4);
    write_reg(REG_REGEN_BASE, 64'd1);
    write_reg(REG_AUTHORITY, 64'(AUTH_SERVICE));
    send_item(OP_INIT, 5'd1);
    send_item(OP_BURN, 5'd18);
    send_item(OP_BURN, 5'd18);
    send_item(OP_BURN, 5'd18);
    send_item(OP_TICK, 5'd18);
    send_item(OP_TICK, 5'd18);
    // refused burn while full, then a tick that adds nothing but clears starved
    send_item(OP_BURN, 5'd0);
    send_item(OP_TICK, 5'd0);
  endtask

  // random settings under each idling pattern, every run opened by an init
  task automatic test_random_traffic();
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       set_idling(0, 0);
        1:       set_idling(88, 0);
        2:       set_idling(0, 88);
        default: set_idling(23, 23);
      endcase
      repeat (2) begin
        wait_idle();
        randomise_settings();
        send_item(OP_INIT, ActionW'($urandom_range(31)));
        random_items(160);
      end
    end
  endtask

  // result side holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    set_idling(0, 0);
    randomise_settings();
    send_item(OP_INIT, ActionW'($urandom_range(31)));
    hold_left = 60;
    random_items(40);
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.op = OP_CHECK;
    req_if.action = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MAX_BASE;
    cfg_if.data = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_before_init();
    test_cost_lookup();
    test_latched_limits();
    test_zero_rate_and_drain();
    test_random_traffic();
    test_backpressure();

    wait_idle();
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
